[src/lpht_pkg.sv]
// Package for the linear probing hash table: field widths, operation and
// status codes shared by the interfaces, the top level and the checker.
// No dependencies.
package lpht_pkg;

  localparam int KeyInW  = 16;
  localparam int FuncW   = 2;
  localparam int StatusW = 3;
  localparam int SlotW   = 4;
  localparam int CfgW    = 5;

  localparam logic [CfgW-1:0] CfgSizeReset = 5'd12;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_RSVD5     = 3'd5,
    ST_RSVD6     = 3'd6,
    ST_RSVD7     = 3'd7
  } status_e;

endpackage

[src/lpht_if.sv]
// Handshake interfaces of the hash table: request, response and
// configuration channels. Depends on lpht_pkg.
interface lpht_req_if;
  logic                        valid;
  logic                        ready;
  lpht_pkg::func_e             func;
  logic [lpht_pkg::KeyInW-1:0] key;
  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface lpht_rsp_if;
  logic                       valid;
  logic                       ready;
  lpht_pkg::status_e          status;
  logic [lpht_pkg::SlotW-1:0] slot_index;
  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

interface lpht_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lpht_pkg::CfgW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/lpht_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/linear_probe_hash_table.sv]
// Linear probing hash table. Insert/search: a restoring modulo of the key by the active size,
// one cycle per probed slot (1..table size), then a response state that loads the output
// register once it is free. Clear sweeps all TABLE_DEPTH slots of the valid memory and then
// responds; the unused code goes straight to the response state. The modulo divider and the
// probe loop set the rate; a request is done before the next is taken. Reset is asynchronous,
// active low, and starts a pass that empties the valid memory.
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpht_cfg_if.sink  cfg_i,
  lpht_req_if.sink  req_i,
  lpht_rsp_if.source rsp_o
);

  import lpht_pkg::*;

  // Address width of the slot memories and width of a slot count that can
  // hold TABLE_DEPTH itself.
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);
  localparam logic [SW-1:0] DepthCnt = SW'(TABLE_DEPTH);
  // Keys are used within KEY_WIDTH bits of the 16-bit key field.
  localparam logic [KeyInW-1:0] KeyMask =
      (KEY_WIDTH >= KeyInW) ? {KeyInW{1'b1}} : KeyInW'((32'd1 << KEY_WIDTH) - 32'd1);
  localparam logic [3:0] ModLastBit = 4'(KeyInW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD,
    S_PROBE,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [CfgW-1:0]     table_size_q;
  func_e               func_q;
  logic [KeyInW-1:0]   key_q;
  logic [KeyInW-1:0]   shreg_q;
  logic [3:0]          bit_cnt_q;
  logic [SW-1:0]       rem_q;
  logic [AW-1:0]       probe_addr_q;
  logic [SW-1:0]       probe_cnt_q;
  logic [AW-1:0]       clr_addr_q;
  logic                clr_rsp_q;
  status_e             res_status_q;
  logic [AW-1:0]       res_slot_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [SlotW-1:0]    out_slot_q;

  // Active size: a size of zero acts as one, anything above the depth
  // is clamped to the depth.
  logic [SW-1:0] size;
  always_comb begin
    if (table_size_q == '0) begin
      size = SW'(1);
    end else if (int'(table_size_q) > TABLE_DEPTH) begin
      size = DepthCnt;
    end else begin
      size = SW'(table_size_q);
    end
  end

  // One restoring step of key modulo size per cycle, MSB first.
  logic [SW:0]   mod_t;
  logic [SW:0]   mod_r;
  logic [SW-1:0] rem_next;
  always_comb begin
    mod_t    = {rem_q, shreg_q[KeyInW-1]};
    mod_r    = (mod_t >= {1'b0, size}) ? (mod_t - {1'b0, size}) : mod_t;
    rem_next = mod_r[SW-1:0];
  end

  // Next slot along the probe path, wrapping at the active size.
  logic [SW-1:0] addr_inc;
  logic [AW-1:0] next_addr;
  logic [SW-1:0] cnt_inc;
  logic          lap_done;
  assign addr_inc  = SW'(probe_addr_q) + SW'(1);
  assign next_addr = (addr_inc == size) ? '0 : addr_inc[AW-1:0];
  assign cnt_inc   = probe_cnt_q + SW'(1);
  assign lap_done  = (cnt_inc == size);

  // Slot memories: one for keys, one for valid bits. Only the valid memory
  // is swept on reset and on clear.
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 key_we;
  logic                 vld_we;
  logic [AW-1:0]        wr_addr;
  logic                 vld_wdata;
  logic [KEY_WIDTH-1:0] key_stored;
  logic [KEY_WIDTH-1:0] key_rdata;
  logic                 vld_rdata;

  assign key_stored = KEY_WIDTH'(key_q);

  logic key_match;
  assign key_match = (key_rdata == key_stored);

  logic rsp_free;
  assign rsp_free = !out_valid_q || rsp_o.ready;

  logic req_xfer;
  assign req_xfer = req_i.valid && req_i.ready;

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = probe_addr_q;
    key_we    = 1'b0;
    vld_we    = 1'b0;
    wr_addr   = probe_addr_q;
    vld_wdata = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        vld_we  = 1'b1;
        wr_addr = clr_addr_q;
      end
      S_MOD: begin
        // The home slot is read on the last divider step.
        rd_en   = (bit_cnt_q == '0);
        rd_addr = rem_next[AW-1:0];
      end
      S_PROBE: begin
        // Keep reading ahead one slot; the data is ignored once we stop.
        rd_en   = 1'b1;
        rd_addr = next_addr;
        if (func_q == FUNC_INSERT && !vld_rdata) begin
          key_we    = 1'b1;
          vld_we    = 1'b1;
          vld_wdata = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  lpht_ram #(
    .Width (KEY_WIDTH),
    .Depth (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_addr),
    .wdata_i (key_stored),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  lpht_ram #(
    .Width (1),
    .Depth (TABLE_DEPTH)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (wr_addr),
    .wdata_i (vld_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (vld_rdata)
  );

  // A new request is taken only in idle; the output register lets the
  // next request start while the previous response waits for its transfer.
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // The slot index field is four bits wide whatever the depth.
  logic [AW+SlotW-1:0] slot_wide;
  assign slot_wide = {{SlotW{1'b0}}, res_slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      table_size_q <= CfgSizeReset;
      clr_addr_q   <= '0;
      clr_rsp_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_NOT_FOUND;
      out_slot_q   <= '0;
      func_q       <= FUNC_RSVD;
      key_q        <= '0;
      shreg_q      <= '0;
      bit_cnt_q    <= '0;
      rem_q        <= '0;
      probe_addr_q <= '0;
      probe_cnt_q  <= '0;
      res_status_q <= ST_NOT_FOUND;
      res_slot_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        table_size_q <= cfg_i.data;
      end

      // In the response state the output register is reloaded below instead.
      if (out_valid_q && rsp_o.ready && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_xfer) begin
            func_q       <= req_i.func;
            key_q        <= req_i.key & KeyMask;
            shreg_q      <= req_i.key & KeyMask;
            bit_cnt_q    <= ModLastBit;
            rem_q        <= '0;
            res_slot_q   <= '0;
            res_status_q <= ST_NOT_FOUND;
            unique case (req_i.func)
              FUNC_CLEAR: begin
                clr_addr_q <= '0;
                clr_rsp_q  <= 1'b1;
                state_q    <= S_CLEAR;
              end
              FUNC_INSERT, FUNC_SEARCH: begin
                state_q <= S_MOD;
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == LastAddr) begin
            res_status_q <= ST_CLEARED;
            res_slot_q   <= '0;
            state_q      <= clr_rsp_q ? S_RESP : S_IDLE;
          end
        end
        S_MOD: begin
          rem_q     <= rem_next;
          shreg_q   <= {shreg_q[KeyInW-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q - 4'd1;
          if (bit_cnt_q == '0) begin
            probe_addr_q <= rem_next[AW-1:0];
            probe_cnt_q  <= '0;
            state_q      <= S_PROBE;
          end
        end
        S_PROBE: begin
          probe_addr_q <= next_addr;
          probe_cnt_q  <= cnt_inc;
          if (func_q == FUNC_INSERT) begin
            if (!vld_rdata) begin
              res_status_q <= ST_INSERTED;
              res_slot_q   <= probe_addr_q;
              state_q      <= S_RESP;
            end else if (lap_done) begin
              res_status_q <= ST_FULL;
              state_q      <= S_RESP;
            end
          end else begin
            if (!vld_rdata) begin
              res_status_q <= ST_NOT_FOUND;
              state_q      <= S_RESP;
            end else if (key_match) begin
              res_status_q <= ST_FOUND;
              res_slot_q   <= probe_addr_q;
              state_q      <= S_RESP;
            end else if (lap_done) begin
              res_status_q <= ST_NOT_FOUND;
              state_q      <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= slot_wide[SlotW-1:0];
            clr_rsp_q    <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot_index = out_slot_q;

endmodule

[src/lpht_checker.sv]
// Port-level checker for the hash table, bound to the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
module lpht_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [lpht_pkg::StatusW-1:0] rsp_status_i,
  input logic [lpht_pkg::SlotW-1:0] rsp_slot_i
);

  import lpht_pkg::*;

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_slot_i))
    else $error("response changed while stalled");

  // Only one request is in work: after a transfer the input closes.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // Responses without a slot carry a zero slot index.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_NOT_FOUND || rsp_status_i == ST_FULL ||
                    rsp_status_i == ST_CLEARED) |-> rsp_slot_i == '0)
    else $error("slot index set on a response without a slot");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot_index)
);
